// ===== hw/rtl/ipv4_udp_receive_checker_unit_assert.svh =====
// assertion macros for the ipv4 udp receive checker
// used by the port checker; expects a clock i_clk and reset i_rst_n in scope
`ifndef IPV4_UDP_RECEIVE_CHECKER_UNIT_ASSERT_SVH
`define IPV4_UDP_RECEIVE_CHECKER_UNIT_ASSERT_SVH

// checked while out of reset
`define URC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define URC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hw/rtl/urc_pkg.sv =====
// shared types, constants and functions for the ipv4 udp receive checker
// no dependencies
package urc_pkg;

    localparam int COUNTER_WIDTH_DEF = 32;
    localparam int QUEUE_DEPTH_DEF   = 4;

    localparam logic [7:0]  PROTO_UDP = 8'h11;
    localparam logic [15:0] ONES16    = 16'hFFFF;
    localparam logic [15:0] UDP_PSEUDO_PROTO = 16'h0011;

    typedef enum logic [2:0] {
        ST_ACCEPT    = 3'd0,
        ST_BAD_IP    = 3'd1,
        ST_NOT_UDP   = 3'd2,
        ST_BAD_UDP   = 3'd3,
        ST_TRUNCATED = 3'd4
    } t_status;

    typedef struct packed {
        logic [15:0] packet_word;
        logic        last;
        logic        odd_tail;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [15:0] payload_length;
        logic [31:0] packets_seen;
        logic [31:0] bad_header_count;
    } t_result;

    // per-packet summary handed from front to back
    typedef struct packed {
        logic [15:0] hsum;
        logic [15:0] usum;
        logic [4:0]  hw;
        logic [7:0]  proto;
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [15:0] ulen;
        logic [15:0] sumf;
        logic [17:0] rcv;
    } t_pkt;

    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    // bytes of a udp word at byte offset off that fall inside the udp length
    function automatic logic [15:0] udp_part(input logic [15:0] w, input logic [16:0] off,
                                             input logic [15:0] ulen);
        logic [17:0] o1;
        o1 = {1'b0, off} + 18'd1;
        if (off >= {1'b0, ulen}) begin
            return 16'd0;
        end else if (o1 >= {2'b00, ulen}) begin
            return {w[15:8], 8'h00};
        end
        return w;
    endfunction

endpackage

// ===== hw/rtl/ipv4_udp_receive_checker_unit.sv =====
// ipv4 udp receive checker, top level
// depends on urc_pkg, urc_front, urc_queue, urc_back
//
// usage:
//   input channel (i_valid / o_stall / i_req) carries one 16-bit big-endian
//   packet word per request, header first, with last and odd_tail marks
//   output channel (o_valid / i_stall / o_result) carries one verdict per
//   packet with captured addresses, ports, payload length and counters
//   config channel (i_cfg_valid / o_cfg_ready / i_cfg_data) writes the udp
//   check enable; always ready, write only while idle
// throughput: one word per cycle; o_stall rises only when the summary queue
//   (QUEUE_DEPTH packets) is full, which happens only under output stall
// path: after the last word is taken, the queue entry is written on the accepting
//   edge, then the checksum sum stage and then the output register are loaded,
//   after which the verdict shows on o_valid
// reset: counters, captures and word position clear, udp check enabled
// receiver stall: result holds; the pipeline then the queue fill, then the
//   input stalls
module ipv4_udp_receive_checker_unit #(
    parameter int COUNTER_WIDTH = urc_pkg::COUNTER_WIDTH_DEF,
    parameter int QUEUE_DEPTH   = urc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  urc_pkg::t_req    i_req,
    output logic             o_valid,
    input  logic             i_stall,
    output urc_pkg::t_result o_result,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic             i_cfg_data
);
    import urc_pkg::*;

    logic r_udp_en;
    logic acc, push, pop, q_valid, q_full;
    t_pkt f_pkt, q_pkt;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = q_full;
    assign acc         = i_valid && !q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_udp_en <= 1'b1;
        end else if (i_cfg_valid) begin
            r_udp_en <= i_cfg_data;
        end
    end

    urc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc),
        .i_req   (i_req),
        .o_push  (push),
        .o_pkt   (f_pkt)
    );

    urc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pkt   (f_pkt),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_pkt   (q_pkt)
    );

    urc_back #(.COUNTER_WIDTH(COUNTER_WIDTH)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_udp_en  (r_udp_en),
        .i_q_valid (q_valid),
        .i_pkt     (q_pkt),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_result  (o_result)
    );

endmodule

// ===== hw/rtl/urc_front.sv =====
// front end: takes packet words, runs header and udp sums, captures fields
// depends on urc_pkg; emits one packet summary per last word
module urc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_acc,
    input  urc_pkg::t_req i_req,
    output logic          o_push,
    output urc_pkg::t_pkt o_pkt
);
    import urc_pkg::*;

    logic [15:0] r_idx, n_idx;
    logic [15:0] r_hsum, n_hsum, r_usum, n_usum;
    logic [4:0]  r_hw, n_hw;
    logic [7:0]  r_proto, n_proto;
    logic [31:0] r_src, n_src, r_dst, n_dst;
    logic [15:0] r_sport, n_sport, r_dport, n_dport, r_ulen, n_ulen, r_sumf, n_sumf;

    logic        odd, first;
    logic [15:0] w, k;
    logic [15:0] b_hsum, b_usum, b_ulen;

    always_comb begin
        odd   = i_req.last & i_req.odd_tail;
        w     = odd ? {i_req.packet_word[15:8], 8'h00} : i_req.packet_word;
        first = (r_idx == 16'd0);
        n_hw    = first ? {w[11:8], 1'b0} : r_hw;
        b_hsum  = first ? 16'd0 : r_hsum;
        b_usum  = first ? 16'd0 : r_usum;
        b_ulen  = first ? 16'd0 : r_ulen;
        n_proto = first ? 8'd0  : r_proto;
        n_src   = first ? 32'd0 : r_src;
        n_dst   = first ? 32'd0 : r_dst;
        n_sport = first ? 16'd0 : r_sport;
        n_dport = first ? 16'd0 : r_dport;
        n_ulen  = b_ulen;
        n_sumf  = first ? 16'd0 : r_sumf;
        n_hsum  = b_hsum;
        n_usum  = b_usum;
        k       = r_idx - {11'd0, n_hw};

        if (r_idx < {11'd0, n_hw}) begin
            n_hsum = oc_add(b_hsum, w);
        end

        case (r_idx)
            16'd4: n_proto = w[7:0];
            16'd6: n_src[31:16] = w;
            16'd7: n_src[15:0] = w;
            16'd8: n_dst[31:16] = w;
            16'd9: n_dst[15:0] = w;
            default: ;
        endcase

        if (r_idx >= {11'd0, n_hw}) begin
            case (k)
                16'd0: n_sport = w;
                16'd1: n_dport = w;
                16'd2: n_ulen = w;
                16'd3: n_sumf = w;
                default: n_usum = oc_add(b_usum, udp_part(w, {k, 1'b0}, b_ulen));
            endcase
        end

        if (i_req.last) begin
            n_idx = 16'd0;
        end else if (r_idx != ONES16) begin
            n_idx = r_idx + 16'd1;
        end else begin
            n_idx = r_idx;
        end

        o_pkt.hsum  = n_hsum;
        o_pkt.usum  = n_usum;
        o_pkt.hw    = n_hw;
        o_pkt.proto = n_proto;
        o_pkt.src   = n_src;
        o_pkt.dst   = n_dst;
        o_pkt.sport = n_sport;
        o_pkt.dport = n_dport;
        o_pkt.ulen  = n_ulen;
        o_pkt.sumf  = n_sumf;
        o_pkt.rcv   = {1'b0, r_idx, 1'b0} + 18'd2 - {17'd0, odd};
        o_push      = i_acc & i_req.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 16'd0;
            r_hsum  <= 16'd0;
            r_usum  <= 16'd0;
            r_hw    <= 5'd0;
            r_proto <= 8'd0;
            r_src   <= 32'd0;
            r_dst   <= 32'd0;
            r_sport <= 16'd0;
            r_dport <= 16'd0;
            r_ulen  <= 16'd0;
            r_sumf  <= 16'd0;
        end else if (i_acc) begin
            r_idx   <= n_idx;
            r_hsum  <= n_hsum;
            r_usum  <= n_usum;
            r_hw    <= n_hw;
            r_proto <= n_proto;
            r_src   <= n_src;
            r_dst   <= n_dst;
            r_sport <= n_sport;
            r_dport <= n_dport;
            r_ulen  <= n_ulen;
            r_sumf  <= n_sumf;
        end
    end

endmodule

// ===== hw/rtl/urc_queue.sv =====
// short queue of packet summaries between front and back
// depends on urc_pkg
module urc_queue #(
    parameter int DEPTH = urc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  urc_pkg::t_pkt i_pkt,
    input  logic          i_pop,
    output logic          o_valid,
    output logic          o_full,
    output urc_pkg::t_pkt o_pkt
);
    import urc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_pkt          r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    assign o_valid = (r_cnt != CW'(0));
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_pkt   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_pkt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

// ===== hw/rtl/urc_back.sv =====
// back end: verdict, pseudo-header checksum, counters and output register
// depends on urc_pkg
module urc_back #(
    parameter int COUNTER_WIDTH = urc_pkg::COUNTER_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_udp_en,
    input  logic             i_q_valid,
    input  urc_pkg::t_pkt    i_pkt,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output urc_pkg::t_result o_result
);
    import urc_pkg::*;

    logic        r_s1_valid, r_out_valid;
    logic [2:0]  r_s1_status;
    logic        r_s1_chk;
    logic [19:0] r_s1_sum;
    logic [31:0] r_s1_src, r_s1_dst;
    logic [15:0] r_s1_sport, r_s1_dport, r_s1_ulen;
    t_result     r_out;

    logic [COUNTER_WIDTH-1:0] r_pkt_cnt, n_pkt_cnt, r_bad_cnt, n_bad_cnt;
    logic [63:0] pkt_wide, bad_wide;

    logic        adv_out, s1_take;
    logic [2:0]  n_status;
    logic        n_chk;
    logic [17:0] hw2, udpb;
    logic [19:0] n_sum;
    logic [16:0] fold1;
    logic [15:0] fold2;
    logic [2:0]  fin_status;

    always_comb begin
        adv_out = !r_out_valid || !i_stall;
        s1_take = !r_s1_valid || adv_out;
        o_pop   = i_q_valid && s1_take;

        hw2  = {12'd0, i_pkt.hw, 1'b0};
        udpb = i_pkt.rcv - hw2;
        n_chk = 1'b0;
        if (i_pkt.hw < 5'd10 || i_pkt.rcv < hw2) begin
            n_status = ST_TRUNCATED;
        end else if (i_pkt.hsum != ONES16) begin
            n_status = ST_BAD_IP;
        end else if (i_pkt.proto != PROTO_UDP) begin
            n_status = ST_NOT_UDP;
        end else if (udpb < 18'd8 || udpb < {2'b00, i_pkt.ulen}) begin
            n_status = ST_TRUNCATED;
        end else begin
            n_status = ST_ACCEPT;
            n_chk    = i_udp_en && (i_pkt.sumf != 16'd0);
        end

        n_sum = {4'd0, i_pkt.usum} + {4'd0, i_pkt.src[31:16]} + {4'd0, i_pkt.src[15:0]}
              + {4'd0, i_pkt.dst[31:16]} + {4'd0, i_pkt.dst[15:0]}
              + {4'd0, UDP_PSEUDO_PROTO} + {4'd0, i_pkt.ulen}
              + {4'd0, udp_part(i_pkt.sport, 17'd0, i_pkt.ulen)}
              + {4'd0, udp_part(i_pkt.dport, 17'd2, i_pkt.ulen)}
              + {4'd0, udp_part(i_pkt.ulen, 17'd4, i_pkt.ulen)}
              + {4'd0, udp_part(i_pkt.sumf, 17'd6, i_pkt.ulen)};

        fold1 = {1'b0, r_s1_sum[15:0]} + {13'd0, r_s1_sum[19:16]};
        fold2 = fold1[15:0] + {15'd0, fold1[16]};
        if (r_s1_chk) begin
            fin_status = (fold2 != ONES16) ? ST_BAD_UDP : ST_ACCEPT;
        end else begin
            fin_status = r_s1_status;
        end

        n_pkt_cnt = r_pkt_cnt + COUNTER_WIDTH'(1);
        n_bad_cnt = (fin_status == ST_BAD_IP) ? r_bad_cnt + COUNTER_WIDTH'(1) : r_bad_cnt;
        pkt_wide  = 64'(n_pkt_cnt);
        bad_wide  = 64'(n_bad_cnt);
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_status <= n_status;
            r_s1_chk    <= n_chk;
            r_s1_sum    <= n_sum;
            r_s1_src    <= i_pkt.src;
            r_s1_dst    <= i_pkt.dst;
            r_s1_sport  <= i_pkt.sport;
            r_s1_dport  <= i_pkt.dport;
            r_s1_ulen   <= i_pkt.ulen;
        end
        if (r_s1_valid && adv_out) begin
            r_out.status           <= fin_status;
            r_out.source_address   <= r_s1_src;
            r_out.dest_address     <= r_s1_dst;
            r_out.source_port      <= r_s1_sport;
            r_out.dest_port        <= r_s1_dport;
            r_out.payload_length   <= (r_s1_ulen >= 16'd8) ? r_s1_ulen - 16'd8 : 16'd0;
            r_out.packets_seen     <= pkt_wide[31:0];
            r_out.bad_header_count <= bad_wide[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pkt_cnt   <= '0;
            r_bad_cnt   <= '0;
        end else begin
            if (s1_take) begin
                r_s1_valid <= i_q_valid;
            end
            if (adv_out) begin
                r_out_valid <= r_s1_valid;
            end
            if (r_s1_valid && adv_out) begin
                r_pkt_cnt <= n_pkt_cnt;
                r_bad_cnt <= n_bad_cnt;
            end
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

// ===== hw/rtl/urc_checker.sv =====
// port checker for the ipv4 udp receive checker, bound to the top level
// depends on urc_pkg and ipv4_udp_receive_checker_unit_assert.svh
`include "ipv4_udp_receive_checker_unit_assert.svh"

module urc_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             o_stall,
    input urc_pkg::t_req    i_req,
    input logic             o_valid,
    input logic             i_stall,
    input urc_pkg::t_result o_result,
    input logic             i_cfg_valid,
    input logic             o_cfg_ready,
    input logic             i_cfg_data
);
    import urc_pkg::*;

    `URC_ASSERT(a_out_hold, o_valid && i_stall |=> o_valid && $stable(o_result), "output dropped")
    `URC_ASSERT_ALWAYS(a_rst_quiet, !i_rst_n |=> !o_valid && !o_stall, "busy after reset")
    `URC_ASSERT(a_cnt_step, o_valid && !i_stall ##1 o_valid |-> o_result.packets_seen == $past(o_result.packets_seen) + 32'd1 || $past(o_result.packets_seen) == 32'hFFFFFFFF, "packet count skipped")
    `URC_ASSERT(a_bad_step, o_valid && !i_stall && o_result.status != ST_BAD_IP ##1 o_valid |-> o_result.status == ST_BAD_IP || o_result.bad_header_count == $past(o_result.bad_header_count), "bad count moved")

endmodule

bind ipv4_udp_receive_checker_unit urc_checker u_urc_checker (.*);
